[rtl/netc_pkg.sv]
package netc_pkg;

	// Stored element kinds on the func input
	localparam logic [2:0] KIND_I8  = 3'd0;
	localparam logic [2:0] KIND_I16 = 3'd1;
	localparam logic [2:0] KIND_I32 = 3'd2;
	localparam logic [2:0] KIND_F64 = 3'd3;
	localparam logic [2:0] KIND_C16 = 3'd4;
	localparam logic [2:0] KIND_C32 = 3'd5;

	// Result type codes
	localparam logic [2:0] TY_BIT = 3'd0;
	localparam logic [2:0] TY_I8  = 3'd1;
	localparam logic [2:0] TY_I16 = 3'd2;
	localparam logic [2:0] TY_I32 = 3'd3;
	localparam logic [2:0] TY_F64 = 3'd4;
	localparam logic [2:0] TY_C8  = 3'd5;
	localparam logic [2:0] TY_C16 = 3'd6;
	localparam logic [2:0] TY_C32 = 3'd7;

	// Range bounds
	localparam logic [31:0] I8_MAX  = 32'd127;
	localparam logic [31:0] I16_MAX = 32'd32767;
	localparam logic [31:0] C8_MAX  = 32'h0000_00ff;
	localparam logic [31:0] C16_MAX = 32'h0000_ffff;

	// IEEE double layout
	localparam int          F64_MAN_W = 52;
	localparam logic [10:0] F64_BIAS  = 11'd1023;
	localparam logic [10:0] F64_EXP_MAX = 11'h7ff;

	// Folded contribution of one word
	typedef struct packed {
		logic [31:0] bits;
		logic        not_int;
	} fold_t;

endpackage

[rtl/netc_fold.sv]
module netc_fold import netc_pkg::*; (
	input  logic [2:0]  func,
	input  logic [63:0] element,
	output fold_t       fold
);

	logic [10:0] ex;
	logic [51:0] man;
	logic        neg;
	logic [10:0] e_unb;
	logic [5:0]  sh;
	logic [52:0] frac_mask;
	logic [52:0] mag_full;
	logic [31:0] mag;
	logic        f_ok;
	logic [31:0] f_int;
	logic [31:0] c16s;

	// Sign fold: clear bit 0, invert negatives
	function automatic logic [31:0] fold_signed(input logic [31:0] c);
		fold_signed = {c[31:1], 1'b0} ^ {32{c[31]}};
	endfunction

	// Double to i32 conversion check
	always_comb begin
		ex        = element[62:52];
		man       = element[51:0];
		neg       = element[63];
		e_unb     = ex - F64_BIAS;
		sh        = 6'(F64_MAN_W) - {1'b0, e_unb[4:0]};
		frac_mask = (53'd1 << sh) - 53'd1;
		mag_full  = {1'b1, man} >> sh;
		mag       = mag_full[31:0];
		f_ok      = 1'b0;
		f_int     = '0;
		if (ex == F64_EXP_MAX) begin
			f_ok = 1'b0;
		end else if (ex == 11'd0) begin
			f_ok = (man == '0);
		end else if (ex < F64_BIAS || e_unb > 11'd31) begin
			f_ok = 1'b0;
		end else if ((({1'b0, man}) & frac_mask) != '0) begin
			f_ok = 1'b0;
		end else if (neg) begin
			f_ok  = (mag <= 32'h8000_0000);
			f_int = 32'd0 - mag;
		end else begin
			f_ok  = (mag <= 32'h7fff_ffff);
			f_int = mag;
		end
	end

	// Per-kind fold
	always_comb begin
		c16s = {{16{element[15]}}, element[15:0]};
		fold = '0;
		case (func)
			KIND_I8:  fold.bits = {24'd0, element[7:0]};
			KIND_I16: fold.bits = fold_signed(c16s);
			KIND_I32: fold.bits = fold_signed(element[31:0]);
			KIND_F64: begin
				fold.bits    = f_ok ? fold_signed(f_int) : '0;
				fold.not_int = !f_ok;
			end
			KIND_C16: fold.bits = {16'd0, element[15:0]};
			default:  fold.bits = element[31:0];
		endcase
	end

endmodule

[rtl/narrowest_element_type_classifier.sv]
// Throughput: one input word per cycle while in_stall is low; one result word per array.
// Stage 1 registers the input word; the fold into the range accumulator and the
// verdict on a last word are combinational from stage 1 to the result register.
// Input stalls only while a last word in stage 1 waits behind a stalled result.
// Reset (arst_n low, asynchronous) clears valids, accumulator and the not-integral flag.
module narrowest_element_type_classifier import netc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [63:0] element,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_type,
	output logic        narrowed
);

	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [63:0] element_s1;
	logic        last_s1;
	logic [31:0] acc_q;
	logic        not_int_q;
	logic        out_valid_q;
	logic [2:0]  result_type_q;
	logic        narrowed_q;

	logic        in_acc;
	logic        adv;
	logic        out_load;
	fold_t       fold;
	logic [31:0] acc_nx;
	logic        not_int_nx;
	logic [2:0]  res_ty;
	logic [2:0]  stored_ty;

	// Handshake: stage 1 holds a last word while the result is still stalled
	assign adv      = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;
	assign out_load = adv && last_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1    <= func;
			element_s1 <= element;
			last_s1    <= last;
		end
	end

	netc_fold u_fold (
		.func    (func_s1),
		.element (element_s1),
		.fold    (fold)
	);

	assign acc_nx     = acc_q | fold.bits;
	assign not_int_nx = not_int_q | fold.not_int;

	// Verdict from the updated state and the last word's kind
	always_comb begin
		res_ty    = TY_C8;
		stored_ty = TY_C32;
		case (func_s1)
			KIND_I8: begin
				stored_ty = TY_I8;
				res_ty    = (acc_nx > 32'd1) ? TY_I8 : TY_BIT;
			end
			KIND_I16: begin
				stored_ty = TY_I16;
				if (acc_nx > I8_MAX)     res_ty = TY_I16;
				else if (acc_nx != '0)   res_ty = TY_I8;
				else                     res_ty = TY_BIT;
			end
			KIND_I32, KIND_F64: begin
				stored_ty = (func_s1 == KIND_F64) ? TY_F64 : TY_I32;
				if (func_s1 == KIND_F64 && not_int_nx) res_ty = TY_F64;
				else if (acc_nx > I16_MAX)              res_ty = TY_I32;
				else if (acc_nx > I8_MAX)               res_ty = TY_I16;
				else if (acc_nx != '0)                  res_ty = TY_I8;
				else                                    res_ty = TY_BIT;
			end
			default: begin
				stored_ty = (func_s1 == KIND_C16) ? TY_C16 : TY_C32;
				if (acc_nx > C16_MAX)     res_ty = TY_C32;
				else if (acc_nx > C8_MAX) res_ty = TY_C16;
				else                      res_ty = TY_C8;
			end
		endcase
	end

	// Range accumulator and not-integral flag, cleared after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			not_int_q <= 1'b0;
		end else if (adv) begin
			acc_q     <= last_s1 ? '0 : acc_nx;
			not_int_q <= last_s1 ? 1'b0 : not_int_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_type_q <= res_ty;
			narrowed_q    <= (res_ty != stored_ty);
		end
	end

	assign out_valid   = out_valid_q;
	assign result_type = result_type_q;
	assign narrowed    = narrowed_q;

`ifndef SYNTHESIS
	// State is clean after an array closes
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> acc_q == '0 && !not_int_q)
		else $error("accumulator not cleared after last word");

	// Input stalls only while stage 1 is occupied
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage 1");

	// A new result comes only from a last word leaving stage 1
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result without a last word");

	// An f64 verdict only arises from stored f64, so it is never narrowed
	a_f64_not_narrowed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_type_q == TY_F64 |-> !narrowed_q)
		else $error("f64 result flagged as narrowed");

	// A stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !out_load)
		else $error("result register overwritten while stalled");
`endif

endmodule
